/* rtl/psa_pkg.sv */
// Shared constants, register codes and the exponent table of the soft seed assignment core.
package psa_pkg;

   // Seeds that the register file holds, and the pixel field widths.
   localparam int MAX_SEEDS  = 4;
   localparam int SEED_IDX_W = 2;
   localparam int CHAN_BITS  = 8;
   localparam int COORD_W    = 10;
   localparam int COLOR_W    = 24;
   localparam int POS_W      = 20;
   localparam int PROB_W     = 16;
   localparam int CSR_IDX_W  = 3;

   // Register map: four colour registers, then four position registers.
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_BASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_BASE   = 3'd4;

   // Defaults of the top level parameters.
   localparam int NUM_SEEDS_DEF  = 4;
   localparam int COORD_BITS_DEF = 10;
   localparam int PROB_BITS_DEF  = 16;

   // Weight arithmetic: one table entry per bit of the scaled distance.
   localparam int EXP_BITS = 12;
   localparam int W_BITS   = 25;

   // exp(-2^b/160) in unsigned Q0.32.
   localparam logic [31:0] EXPT [EXP_BITS] = '{
      32'd4268207462, 32'd4241614355, 32'd4188924176, 32'd4085499269,
      32'd3886247119, 32'd3516421809, 32'd2879002676, 32'd1929853206,
      32'd867138942,  32'd175072333,  32'd7136334,    32'd11857
   };

endpackage

/* rtl/psa_if.sv */
// Valid/ready channel interfaces for pixel items and result items.
interface psa_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan_a;
   logic [7:0] chan_b;
   logic [7:0] chan_c;
   logic [9:0] pixel_x;
   logic [9:0] pixel_y;

   modport source (output valid, chan_a, chan_b, chan_c, pixel_x, pixel_y, input ready);
   modport sink   (input valid, chan_a, chan_b, chan_c, pixel_x, pixel_y, output ready);
endinterface

interface psa_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] prob_0;
   logic [15:0] prob_1;
   logic [15:0] prob_2;
   logic [15:0] prob_3;
   logic [1:0]  best_segment;
   logic        all_weights_zero;

   modport source (output valid, prob_0, prob_1, prob_2, prob_3, best_segment,
                   all_weights_zero, input ready);
   modport sink   (input valid, prob_0, prob_1, prob_2, prob_3, best_segment,
                   all_weights_zero, output ready);
endinterface

/* rtl/psa_isqrt.sv */
// Pipelined floor integer square root, one result bit per stage.
module psa_isqrt #(
   parameter int ROOT_BITS = 15
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [2*ROOT_BITS-1:0]   in_value,
   output logic [ROOT_BITS-1:0]     root
);

   localparam int IN_W  = 2 * ROOT_BITS;
   localparam int REM_W = ROOT_BITS + 2;

   logic [REM_W-1:0]     rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [IN_W-1:0]      val_ff  [ROOT_BITS];

   for (genvar gs = 0; gs < ROOT_BITS; gs++) begin : g_stage
      logic [REM_W-1:0]     rem_p;
      logic [ROOT_BITS-1:0] root_p;
      logic [IN_W-1:0]      val_p;
      logic [REM_W-1:0]     cur;
      logic [REM_W-1:0]     trial;
      logic                 ge;

      if (gs == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign val_p  = in_value;
      end else begin : g_next
         assign rem_p  = rem_ff[gs-1];
         assign root_p = root_ff[gs-1];
         assign val_p  = val_ff[gs-1];
      end

      always_comb begin
         cur   = {rem_p[REM_W-3:0], val_p[IN_W-1:IN_W-2]};
         trial = {root_p, 2'b01};
         ge    = (cur >= trial);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[gs]  <= ge ? (cur - trial) : cur;
            root_ff[gs] <= {root_p[ROOT_BITS-2:0], ge};
            val_ff[gs]  <= {val_p[IN_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[ROOT_BITS-1];

endmodule

/* rtl/psa_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module psa_div #(
   parameter int DEN_BITS = 27,
   parameter int Q_BITS   = 17
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [DEN_BITS+Q_BITS-1:0] num,
   input  logic [DEN_BITS-1:0]        den,
   output logic [Q_BITS-1:0]          quo
);

   localparam int NUM_W = DEN_BITS + Q_BITS;

   logic [DEN_BITS-1:0] rem_ff [Q_BITS];
   logic [Q_BITS-1:0]   low_ff [Q_BITS];
   logic [DEN_BITS-1:0] den_ff [Q_BITS];
   logic [Q_BITS-1:0]   quo_ff [Q_BITS];

   for (genvar gq = 0; gq < Q_BITS; gq++) begin : g_stage
      logic [DEN_BITS-1:0] rem_p;
      logic [Q_BITS-1:0]   low_p;
      logic [DEN_BITS-1:0] den_p;
      logic [Q_BITS-1:0]   quo_p;
      logic [DEN_BITS:0]   t;
      logic [DEN_BITS:0]   diff;
      logic                ge;

      if (gq == 0) begin : g_first
         assign rem_p = num[NUM_W-1:Q_BITS];
         assign low_p = num[Q_BITS-1:0];
         assign den_p = den;
         assign quo_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[gq-1];
         assign low_p = low_ff[gq-1];
         assign den_p = den_ff[gq-1];
         assign quo_p = quo_ff[gq-1];
      end

      always_comb begin
         t    = {rem_p, low_p[Q_BITS-1]};
         diff = t - {1'b0, den_p};
         ge   = (t >= {1'b0, den_p});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[gq] <= ge ? diff[DEN_BITS-1:0] : t[DEN_BITS-1:0];
            low_ff[gq] <= {low_p[Q_BITS-2:0], 1'b0};
            den_ff[gq] <= den_p;
            quo_ff[gq] <= {quo_p[Q_BITS-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[Q_BITS-1];

endmodule

/* rtl/pixel_soft_seed_assignment_core.sv */
// Top level of the soft seed assignment core: seed registers and the full pixel pipeline.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        chan_a, chan_b, chan_c, pixel_x, pixel_y
//   rsp_chan  out        valid/ready        prob_0..prob_3, best_segment, all_weights_zero
//   csr_*     in         write enable only  csr_index, csr_wdata
//
// One pixel item enters per clock cycle unless the result side stalls; each item then
// passes the distance registers, two square roots of R = max(13, COORD_BITS + 5)
// stages each, the exponent stages, the weight, sum, divider and output registers.
// Reset is synchronous and active high; it empties the pipeline and clears
// the seed registers. A stall on the result side freezes every stage at once,
// so no item is lost or repeated, and the block keeps taking items as long as
// the output register is free or is being drained in the same cycle.
module pixel_soft_seed_assignment_core #(
   parameter int NUM_SEEDS  = psa_pkg::NUM_SEEDS_DEF,
   parameter int COORD_BITS = psa_pkg::COORD_BITS_DEF,
   parameter int PROB_BITS  = psa_pkg::PROB_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   psa_req_if.sink                         req_chan,
   psa_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [psa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psa_pkg::COLOR_W-1:0]     csr_wdata
);

   localparam int MS     = psa_pkg::MAX_SEEDS;
   localparam int CB     = COORD_BITS;
   localparam int R      = (COORD_BITS + 5 > 13) ? (COORD_BITS + 5) : 13;
   localparam int SQ_IN  = 2 * R;
   localparam int EXPB   = psa_pkg::EXP_BITS;
   localparam int WB     = psa_pkg::W_BITS;
   localparam int DEN_W  = WB + psa_pkg::SEED_IDX_W;
   localparam int Q_BITS = PROB_BITS + 1;
   localparam int NUM_W  = DEN_W + Q_BITS;
   localparam int PW     = psa_pkg::PROB_W;
   localparam int LAT    = 1 + R + EXPB + 2 + Q_BITS;

   // Seed registers.
   logic [psa_pkg::COLOR_W-1:0] seed_color_ff [MS];
   logic [psa_pkg::POS_W-1:0]   seed_pos_ff   [MS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MS; i++) begin
            seed_color_ff[i] <= '0;
            seed_pos_ff[i]   <= '0;
         end
      end else if (csr_we) begin
         if (csr_index < psa_pkg::CSR_POS_BASE) begin
            seed_color_ff[csr_index[psa_pkg::SEED_IDX_W-1:0]] <= csr_wdata;
         end else begin
            seed_pos_ff[csr_index[psa_pkg::SEED_IDX_W-1:0]] <=
               csr_wdata[psa_pkg::POS_W-1:0];
         end
      end
   end

   // The whole pipeline moves together whenever the output register can take an item.
   logic           en;
   logic [LAT-1:0] valid_ff;
   logic           out_valid_ff;

   assign en             = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[LAT-2:0], req_chan.valid};
         out_valid_ff <= valid_ff[LAT-1];
      end
   end

   // Per seed: squared distances, two square roots and the weight.
   logic [17:0]     dc2_ff [MS];
   logic [2*CB:0]   ds2_ff [MS];
   logic [WB-1:0]   w_ff   [MS];

   for (genvar gk = 0; gk < MS; gk++) begin : g_seed
      logic [7:0]    d0, d1, d2;
      logic [7:0]    sa, sb, sc;
      logic [CB-1:0] px, py, sx, sy, dx, dy;
      logic [15:0]   q0, q1, q2;
      logic [2*CB-1:0] qx, qy;
      logic [R-1:0]  dc, ds;
      logic [R:0]    s;
      logic          zero0;
      logic [31:0]   acc_ff  [EXPB];
      logic          one_ff  [EXPB];
      logic          zero_ff [EXPB];
      logic [EXPB-1:0] s_ff  [EXPB];

      always_comb begin
         sa = seed_color_ff[gk][7:0];
         sb = seed_color_ff[gk][15:8];
         sc = seed_color_ff[gk][23:16];
         px = req_chan.pixel_x[CB-1:0];
         py = req_chan.pixel_y[CB-1:0];
         sx = seed_pos_ff[gk][CB-1:0];
         sy = seed_pos_ff[gk][10+CB-1:10];
         d0 = (req_chan.chan_a > sa) ? (req_chan.chan_a - sa) : (sa - req_chan.chan_a);
         d1 = (req_chan.chan_b > sb) ? (req_chan.chan_b - sb) : (sb - req_chan.chan_b);
         d2 = (req_chan.chan_c > sc) ? (req_chan.chan_c - sc) : (sc - req_chan.chan_c);
         dx = (px > sx) ? (px - sx) : (sx - px);
         dy = (py > sy) ? (py - sy) : (sy - py);
         q0 = d0 * d0;
         q1 = d1 * d1;
         q2 = d2 * d2;
         qx = dx * dx;
         qy = dy * dy;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dc2_ff[gk] <= 18'(q0) + 18'(q1) + 18'(q2);
            ds2_ff[gk] <= (2*CB+1)'(qx) + (2*CB+1)'(qy);
         end
      end

      psa_isqrt #(.ROOT_BITS(R)) u_color_sqrt (
         .clock    (clock),
         .en       (en),
         .in_value (SQ_IN'({dc2_ff[gk], 8'b0})),
         .root     (dc)
      );

      psa_isqrt #(.ROOT_BITS(R)) u_space_sqrt (
         .clock    (clock),
         .en       (en),
         .in_value (SQ_IN'({ds2_ff[gk], 8'b0})),
         .root     (ds)
      );

      // A distance of 256 or more (in units of 1/16) or an unused seed gives no weight.
      assign s     = (R+1)'(dc) + (R+1)'(ds);
      assign zero0 = (|s[R:EXPB]) || (gk >= NUM_SEEDS);

      // One table multiply per distance bit; the accumulator starts at one.
      for (genvar gb = 0; gb < EXPB; gb++) begin : g_exp
         logic [31:0]     acc_p;
         logic            one_p;
         logic            zero_p;
         logic [EXPB-1:0] s_p;
         logic [63:0]     prod;

         if (gb == 0) begin : g_first
            assign acc_p  = '0;
            assign one_p  = 1'b1;
            assign zero_p = zero0;
            assign s_p    = s[EXPB-1:0];
         end else begin : g_next
            assign acc_p  = acc_ff[gb-1];
            assign one_p  = one_ff[gb-1];
            assign zero_p = zero_ff[gb-1];
            assign s_p    = s_ff[gb-1];
         end

         assign prod = {32'b0, acc_p} * {32'b0, psa_pkg::EXPT[gb]} + 64'h0000_0000_8000_0000;

         always_ff @(posedge clock) begin
            if (en) begin
               zero_ff[gb] <= zero_p;
               s_ff[gb]    <= s_p;
               if (s_p[gb]) begin
                  acc_ff[gb] <= one_p ? psa_pkg::EXPT[gb] : prod[63:32];
                  one_ff[gb] <= 1'b0;
               end else begin
                  acc_ff[gb] <= acc_p;
                  one_ff[gb] <= one_p;
               end
            end
         end
      end

      // Round the Q0.32 accumulator to the Q1.24 weight.
      always_ff @(posedge clock) begin
         if (en) begin
            if (zero_ff[EXPB-1]) begin
               w_ff[gk] <= '0;
            end else if (one_ff[EXPB-1]) begin
               w_ff[gk] <= WB'(1) << (WB - 1);
            end else begin
               w_ff[gk] <= WB'((33'(acc_ff[EXPB-1]) + 33'd128) >> 8);
            end
         end
      end
   end

   // Weight sum.
   logic [DEN_W-1:0] sum_in;
   logic [DEN_W-1:0] sum_ff;
   logic [WB-1:0]    wd_ff [MS];

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MS; i++) begin
         sum_in = sum_in + DEN_W'(w_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
         for (int i = 0; i < MS; i++) begin
            wd_ff[i] <= w_ff[i];
         end
      end
   end

   // Normalization: rounded w / sum per seed, with the zero-sum flag riding alongside.
   logic [Q_BITS-1:0] quo [MS];
   logic [Q_BITS-1:0] zl_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         zl_ff <= {zl_ff[Q_BITS-2:0], (sum_ff == '0)};
      end
   end

   for (genvar gd = 0; gd < MS; gd++) begin : g_norm
      logic [NUM_W-1:0] num;

      assign num = NUM_W'({wd_ff[gd], {PROB_BITS{1'b0}}}) + NUM_W'(sum_ff >> 1);

      psa_div #(.DEN_BITS(DEN_W), .Q_BITS(Q_BITS)) u_div (
         .clock (clock),
         .en    (en),
         .num   (num),
         .den   (sum_ff),
         .quo   (quo[gd])
      );
   end

   // Saturation, best segment search and the output register.
   logic [PROB_BITS-1:0]          p_in [MS];
   logic [PROB_BITS-1:0]          bestp;
   logic [psa_pkg::SEED_IDX_W-1:0] best_in;
   logic [PROB_BITS-1:0]          prob_ff [MS];
   logic [psa_pkg::SEED_IDX_W-1:0] best_ff;
   logic                          azero_ff;

   always_comb begin
      for (int i = 0; i < MS; i++) begin
         if (zl_ff[Q_BITS-1] || (i >= NUM_SEEDS)) begin
            p_in[i] = '0;
         end else if (quo[i][PROB_BITS]) begin
            p_in[i] = '1;
         end else begin
            p_in[i] = quo[i][PROB_BITS-1:0];
         end
      end
      best_in = '0;
      bestp   = p_in[0];
      for (int i = 1; i < MS; i++) begin
         if (p_in[i] > bestp) begin
            bestp   = p_in[i];
            best_in = psa_pkg::SEED_IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < MS; i++) begin
            prob_ff[i] <= p_in[i];
         end
         best_ff  <= best_in;
         azero_ff <= zl_ff[Q_BITS-1];
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.prob_0           = PW'(prob_ff[0]);
   assign rsp_chan.prob_1           = PW'(prob_ff[1]);
   assign rsp_chan.prob_2           = PW'(prob_ff[2]);
   assign rsp_chan.prob_3           = PW'(prob_ff[3]);
   assign rsp_chan.best_segment     = best_ff;
   assign rsp_chan.all_weights_zero = azero_ff;

   // A zero-sum item reports no probability and segment zero.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && azero_ff |-> prob_ff[0] == '0 && prob_ff[1] == '0 &&
                                   prob_ff[2] == '0 && prob_ff[3] == '0 && best_ff == '0)
      else $error("zero-sum item carries a probability");

   // Segment zero is reported only when nothing beats it.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && best_ff == '0 |-> prob_ff[0] >= prob_ff[1] &&
                                        prob_ff[0] >= prob_ff[2] && prob_ff[0] >= prob_ff[3])
      else $error("best segment zero is not the maximum");

   // The last seed never carries a probability when it is unused.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (NUM_SEEDS < MS) |-> prob_ff[MS-1] == '0)
      else $error("unused seed has a probability");

   // The pipeline is empty in the first cycle after reset is released.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !out_valid_ff && valid_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
